/* sv/keyword_token_lexer_macros.svh */
// Assertion macros used by the lexer top-level RTL.
`ifndef KEYWORD_TOKEN_LEXER_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_MACROS_SVH

// Condition must hold at every edge outside reset.
`define KTL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define KTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ktl_pkg.sv */
// Types, token kinds and keyword tables of the keyword token lexer.
package ktl_pkg;

   localparam int TOKEN_KIND_BITS = 5;
   localparam int TOKEN_LINE_BITS = 16;
   localparam int TOKEN_POS_BITS  = 20;
   localparam int KW_COUNT        = 8;
   localparam int OP_COUNT        = 7;
   localparam int RSP_DEPTH       = 4;
   localparam int RSP_PTR_BITS    = 2;
   localparam int RSP_CNT_BITS    = 3;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_DONE   = 2'd3
   } mode_type;

   localparam logic [TOKEN_KIND_BITS-1:0] KIND_IDENT    = 5'd0;
   localparam logic [TOKEN_KIND_BITS-1:0] KIND_NUMBER   = 5'd1;
   localparam logic [TOKEN_KIND_BITS-1:0] KIND_KEYWORD0 = 5'd2;
   localparam logic [TOKEN_KIND_BITS-1:0] KIND_OP0      = 5'd10;
   localparam logic [TOKEN_KIND_BITS-1:0] KIND_END      = 5'd17;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   // Keyword text right-aligned: first character in the highest used byte.
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "start", "end", "var", "print", "if", "endif", "while", "endwhile"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd3, 4'd3, 4'd5, 4'd2, 4'd5, 4'd5, 4'd8
   };
   localparam logic [7:0] OP_CHARS [OP_COUNT] = '{
      "+", "-", "*", "/", "=", ">", "<"
   };

   typedef struct packed {
      logic                       alpha;
      logic                       digit;
      logic                       space;
      logic                       newline;
      logic                       op_hit;
      logic [TOKEN_KIND_BITS-1:0] op_kind;
   } char_class_type;

   typedef struct packed {
      logic [TOKEN_KIND_BITS-1:0] kind;
      logic [TOKEN_LINE_BITS-1:0] line;
      logic [TOKEN_POS_BITS-1:0]  start;
      logic [TOKEN_POS_BITS-1:0]  length;
      logic                       last;
   } token_type;

   typedef struct packed {
      logic      first_valid;
      logic      second_valid;
      token_type first;
      token_type second;
   } rsp_push_type;

   // Character i of keyword k; valid only for i below the keyword length.
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
      logic [63:0] text;
      logic [2:0]  sel;
      begin
         text = KW_TEXT[k];
         sel = 3'(KW_LEN[k] - 4'd1 - i);
         kw_char = text[{sel, 3'b000} +: 8];
      end
   endfunction

endpackage

/* sv/ktl_classify.sv */
// Byte classifier and keyword candidate mask update of the lexer.
module ktl_classify (
   input  logic [7:0]              char_byte,
   input  logic [7:0]              mask_sel,
   input  logic [3:0]              seen_sel,
   output ktl_pkg::char_class_type cls,
   output logic [7:0]              mask_ext
);

   always_comb begin
      cls = '0;
      cls.alpha = (char_byte >= "a" && char_byte <= "z") ||
                  (char_byte >= "A" && char_byte <= "Z");
      cls.digit = char_byte >= "0" && char_byte <= "9";
      cls.space = char_byte == " " || (char_byte >= 8'd9 && char_byte <= 8'd13);
      cls.newline = char_byte == ktl_pkg::CHAR_LF;
      cls.op_kind = ktl_pkg::KIND_END;
      for (int k = 0; k < ktl_pkg::OP_COUNT; k++) begin
         if (ktl_pkg::OP_CHARS[k] == char_byte) begin
            cls.op_hit = 1'b1;
            cls.op_kind = ktl_pkg::KIND_OP0 + ktl_pkg::TOKEN_KIND_BITS'(k);
         end
      end
   end

   // Drop every keyword whose next character differs or which is already used up.
   always_comb begin
      for (int k = 0; k < ktl_pkg::KW_COUNT; k++) begin
         mask_ext[k] = mask_sel[k] && (seen_sel < ktl_pkg::KW_LEN[k]) &&
                       (ktl_pkg::kw_char(3'(k), seen_sel) == char_byte);
      end
   end

endmodule

/* sv/ktl_rsp_fifo.sv */
// Four-entry token queue taking up to two tokens per cycle.
module ktl_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  ktl_pkg::rsp_push_type push,
   output logic                 has_room,
   input  logic                 pop,
   output logic                 head_valid,
   output ktl_pkg::token_type   head
);

   ktl_pkg::token_type                  entry_ff [ktl_pkg::RSP_DEPTH];
   logic [ktl_pkg::RSP_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ktl_pkg::RSP_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ktl_pkg::RSP_CNT_BITS-1:0]    count_ff, count_in;
   logic [ktl_pkg::RSP_CNT_BITS-1:0]    push_cnt;

   assign push_cnt   = ktl_pkg::RSP_CNT_BITS'(push.first_valid) +
                       ktl_pkg::RSP_CNT_BITS'(push.second_valid);
   assign has_room   = count_ff <= ktl_pkg::RSP_CNT_BITS'(ktl_pkg::RSP_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ktl_pkg::RSP_PTR_BITS'(push_cnt);
      rd_ptr_in = rd_ptr_ff + ktl_pkg::RSP_PTR_BITS'(pop);
      count_in  = count_ff + push_cnt - ktl_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_ff + ktl_pkg::RSP_PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

/* sv/keyword_token_lexer.sv */
// Streaming lexer: one source byte per word in, tokens out.
//
//   channel | direction | words carry
//   req_    | in        | source_char, end_of_source
//   rsp_    | out       | token_kind, token_line, token_start, token_length, last_of_run
//
// A byte is registered on acceptance and scanned once the queue has room, its tokens
// written into a four-entry queue and offered on rsp_ behind any tokens already queued.
// One byte per cycle is taken while the queue holds at most two tokens; two-token
// words never come back to back, so without rsp_ stalls no byte is ever held back.
// Reset returns to line one, offset zero, with no open token.
// A stall on rsp_ holds the queue; once it holds more than two tokens while a byte waits, req_stall rises.
`include "keyword_token_lexer_macros.svh"

module keyword_token_lexer #(
   parameter int POSITION_BITS = 20,
   parameter int LINE_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_char,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_line,
   output logic [19:0] rsp_token_start,
   output logic [19:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   localparam int PosWideBits  = (POSITION_BITS > ktl_pkg::TOKEN_POS_BITS) ?
                                 POSITION_BITS : ktl_pkg::TOKEN_POS_BITS;
   localparam int LineWideBits = (LINE_BITS > ktl_pkg::TOKEN_LINE_BITS) ?
                                 LINE_BITS : ktl_pkg::TOKEN_LINE_BITS;

   // input stage
   logic                     stage_valid_ff, stage_valid_in;
   logic [7:0]               char_ff;
   logic                     end_ff;
   logic                     accept;
   logic                     fire;

   // scanner state
   ktl_pkg::mode_type        mode_ff, mode_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] origin_ff, origin_in;
   logic [7:0]               mask_ff, mask_in;
   logic [3:0]               seen_ff, seen_in;

   logic [7:0]               mask_sel;
   logic [3:0]               seen_sel;
   logic [7:0]               mask_ext;
   ktl_pkg::char_class_type  cls;

   logic                     stop;
   logic                     handle_idle;
   logic [POSITION_BITS-1:0] pos_inc;
   logic [3:0]               seen_inc;
   logic [POSITION_BITS-1:0] span;
   logic [PosWideBits-1:0]   pos_wide, origin_wide, span_wide;
   logic [LineWideBits-1:0]  line_wide;
   logic [ktl_pkg::TOKEN_KIND_BITS-1:0] ident_kind;

   ktl_pkg::token_type       tok_a, tok_b;
   logic                     emit_a, emit_b;
   ktl_pkg::rsp_push_type    push;
   logic                     has_room;
   ktl_pkg::token_type       head;

   assign fire           = stage_valid_ff && has_room;
   assign req_stall      = stage_valid_ff && !fire;
   assign accept         = req_valid && !req_stall;
   assign stage_valid_in = accept || (stage_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_source_char;
         end_ff  <= req_end_of_source;
      end
   end

   // Fresh identifiers start from the full keyword set.
   assign mask_sel = (mode_ff == ktl_pkg::MODE_IDENT) ? mask_ff : '1;
   assign seen_sel = (mode_ff == ktl_pkg::MODE_IDENT) ? seen_ff : '0;

   ktl_classify u_classify (
      .char_byte (char_ff),
      .mask_sel  (mask_sel),
      .seen_sel  (seen_sel),
      .cls       (cls),
      .mask_ext  (mask_ext)
   );

   assign stop        = end_ff || (char_ff == ktl_pkg::CHAR_NUL);
   assign pos_inc     = (&pos_ff) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign seen_inc    = (&seen_ff) ? seen_ff : seen_ff + 4'd1;
   assign span        = pos_ff - origin_ff;
   assign pos_wide    = PosWideBits'(pos_ff);
   assign origin_wide = PosWideBits'(origin_ff);
   assign span_wide   = PosWideBits'(span);
   assign line_wide   = LineWideBits'(line_ff);

   // Lowest keyword still standing whose length matches.
   always_comb begin
      ident_kind = ktl_pkg::KIND_IDENT;
      for (int k = ktl_pkg::KW_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k] && seen_ff == ktl_pkg::KW_LEN[k]) begin
            ident_kind = ktl_pkg::KIND_KEYWORD0 + ktl_pkg::TOKEN_KIND_BITS'(k);
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      line_in     = line_ff;
      pos_in      = pos_ff;
      origin_in   = origin_ff;
      mask_in     = mask_ff;
      seen_in     = seen_ff;
      emit_a      = 1'b0;
      emit_b      = 1'b0;
      handle_idle = 1'b0;

      tok_a        = '0;
      tok_a.line   = line_wide[ktl_pkg::TOKEN_LINE_BITS-1:0];
      tok_a.start  = origin_wide[ktl_pkg::TOKEN_POS_BITS-1:0];
      tok_a.length = span_wide[ktl_pkg::TOKEN_POS_BITS-1:0];
      tok_b        = '0;
      tok_b.kind   = ktl_pkg::KIND_END;
      tok_b.line   = line_wide[ktl_pkg::TOKEN_LINE_BITS-1:0];
      tok_b.start  = pos_wide[ktl_pkg::TOKEN_POS_BITS-1:0];
      tok_b.last   = 1'b1;

      if (fire) begin
         case (mode_ff)
            ktl_pkg::MODE_DONE: begin
               emit_b = 1'b1;
            end
            ktl_pkg::MODE_IDENT: begin
               if (!stop && (cls.alpha || cls.digit)) begin
                  mask_in = mask_ext;
                  seen_in = seen_inc;
                  pos_in  = pos_inc;
               end else begin
                  emit_a      = 1'b1;
                  tok_a.kind  = ident_kind;
                  mode_in     = ktl_pkg::MODE_IDLE;
                  handle_idle = 1'b1;
               end
            end
            ktl_pkg::MODE_NUMBER: begin
               if (!stop && cls.digit) begin
                  pos_in = pos_inc;
               end else begin
                  emit_a      = 1'b1;
                  tok_a.kind  = ktl_pkg::KIND_NUMBER;
                  mode_in     = ktl_pkg::MODE_IDLE;
                  handle_idle = 1'b1;
               end
            end
            ktl_pkg::MODE_IDLE: begin
               handle_idle = 1'b1;
            end
            default: begin
               handle_idle = 1'b1;
            end
         endcase

         // The closing byte is then scanned as from idle.
         if (handle_idle) begin
            if (stop) begin
               emit_b  = 1'b1;
               mode_in = ktl_pkg::MODE_DONE;
            end else if (cls.space) begin
               if (cls.newline && !(&line_ff)) begin
                  line_in = line_ff + LINE_BITS'(1);
               end
               pos_in = pos_inc;
            end else if (cls.alpha) begin
               mode_in   = ktl_pkg::MODE_IDENT;
               origin_in = pos_ff;
               mask_in   = mask_ext;
               seen_in   = 4'd1;
               pos_in    = pos_inc;
            end else if (cls.digit) begin
               mode_in   = ktl_pkg::MODE_NUMBER;
               origin_in = pos_ff;
               pos_in    = pos_inc;
            end else begin
               emit_b       = 1'b1;
               tok_b.kind   = cls.op_kind;
               tok_b.length = ktl_pkg::TOKEN_POS_BITS'(cls.op_hit);
               pos_in       = pos_inc;
            end
         end
      end

      tok_a.last = !emit_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ktl_pkg::MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         pos_ff    <= '0;
         origin_ff <= '0;
         mask_ff   <= '1;
         seen_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         origin_ff <= origin_in;
         mask_ff   <= mask_in;
         seen_ff   <= seen_in;
      end
   end

   always_comb begin
      push.first_valid  = emit_a || emit_b;
      push.second_valid = emit_a && emit_b;
      push.first        = emit_a ? tok_a : tok_b;
      push.second       = tok_b;
   end

   ktl_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .has_room   (has_room),
      .pop        (rsp_valid && !rsp_stall),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_line   = head.line;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

   `KTL_ASSERT_NEXT(a_done_holds, clock, reset, mode_ff == ktl_pkg::MODE_DONE, mode_ff == ktl_pkg::MODE_DONE, "finished mode left without reset")
   `KTL_ASSERT_ALWAYS(a_line_nonzero, clock, reset, line_ff != '0, "line counter reached zero")
   `KTL_ASSERT_ALWAYS(a_origin_order, clock, reset, (mode_ff != ktl_pkg::MODE_IDENT && mode_ff != ktl_pkg::MODE_NUMBER) || origin_ff <= pos_ff, "open token starts beyond current offset")

endmodule
